[sv/gfd_pkg.sv]
// ----------------------------------------------------------------------------
// gfd_pkg
// Shared constants and types for the gain frame deframer with angle reply.
// ----------------------------------------------------------------------------
package gfd_pkg;

  localparam int RX_WINDOW   = 20;
  localparam int FRAME_BYTES = 9;
  localparam int FIFO_DEPTH  = 2;

  localparam int CntW    = $clog2(RX_WINDOW + 1);
  localparam int IdxW    = $clog2(FRAME_BYTES);
  localparam int FPtrW   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FCntW   = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] HDR_BYTE = 8'hA5;
  localparam logic [7:0] TRL_BYTE = 8'h5A;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_IDLE = 1'b1;

  localparam logic KIND_GAIN  = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  // One nine-byte burst, classified and ready for the back end.
  typedef struct packed {
    logic        gain_ok;
    logic [15:0] kp;
    logic [15:0] kd;
    logic [15:0] sp;
    logic [15:0] ang;
  } job_t;

endpackage

[sv/gfd_in_if.sv]
// ----------------------------------------------------------------------------
// gfd_in_if
// Input channel: received byte or line-idle event, with the current angle.
// ----------------------------------------------------------------------------
interface gfd_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  rx_byte;
  logic signed [15:0] angle_tenths;

  modport source (output valid, action, rx_byte, angle_tenths, input ready);
  modport sink   (input valid, action, rx_byte, angle_tenths, output ready);
endinterface

[sv/gfd_out_if.sv]
// ----------------------------------------------------------------------------
// gfd_out_if
// Output channel: one gain set or one reply byte per word.
// ----------------------------------------------------------------------------
interface gfd_out_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic signed [16:0] angle_kp;
  logic signed [16:0] angle_kd_hundredths;
  logic signed [16:0] speed_kp;
  logic [7:0]         tx_byte;
  logic               last_of_run;

  modport source (output valid, result_kind, angle_kp, angle_kd_hundredths, speed_kp,
                  tx_byte, last_of_run, input ready);
  modport sink   (input valid, result_kind, angle_kp, angle_kd_hundredths, speed_kp,
                  tx_byte, last_of_run, output ready);
endinterface

[sv/gain_frame_deframer_with_angle_reply.sv]
// ----------------------------------------------------------------------------
// gain_frame_deframer_with_angle_reply
// Serial gain-frame deframer: collects a burst, checks a nine-byte frame and
// answers every nine-byte burst with a five-byte angle reply.
//
//   channel  dir  word contents
//   in_i     in   action, rx_byte, angle_tenths
//   out_o    out  result_kind, angle_kp, angle_kd_hundredths, speed_kp,
//                 tx_byte, last_of_run
//
// Input words are taken while the job queue is not full; a byte or a short
// burst makes no output. A nine-byte burst turns into a job of 5 or 6 output
// words, sent one per cycle by the back end while the output is ready.
// A two-job queue lets the front keep taking words while the back end drains;
// input ready drops only while that queue is full.
// Reset clears the burst count, checksum, queue and output valid at once.
// ----------------------------------------------------------------------------
module gain_frame_deframer_with_angle_reply (
  input  logic      clk_i,
  input  logic      rst_ni,
  gfd_in_if.sink    in_i,
  gfd_out_if.source out_o
);
  import gfd_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  job_t q_job_in;
  job_t q_job_out;

  gfd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_job_o  (q_job_in)
  );

  gfd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (q_job_out)
  );

  gfd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_job_i   (q_job_out),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

[sv/gfd_front.sv]
// ----------------------------------------------------------------------------
// gfd_front
// Collects the burst, keeps a running checksum and, on a line-idle event
// ending a nine-byte burst, pushes one classified job into the queue.
// ----------------------------------------------------------------------------
module gfd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  gfd_in_if.sink        in_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output gfd_pkg::job_t q_job_o
);
  import gfd_pkg::*;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      bytes_q [FRAME_BYTES];
  logic            accept;
  logic            store;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign store      = accept && (in_i.action == ACT_BYTE) && (cnt_q < CntW'(FRAME_BYTES));

  always_comb begin
    cnt_d = cnt_q;
    sum_d = sum_q;
    if (accept) begin
      if (in_i.action == ACT_IDLE) begin
        cnt_d = '0;
        sum_d = '0;
      end else if (cnt_q < CntW'(RX_WINDOW)) begin
        cnt_d = cnt_q + CntW'(1);
        // bytes 1..6 form the checksum
        if (cnt_q >= CntW'(1) && cnt_q <= CntW'(6)) begin
          sum_d = sum_q + in_i.rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      bytes_q[cnt_q[IdxW-1:0]] <= in_i.rx_byte;
    end
  end

  assign q_push_o = accept && (in_i.action == ACT_IDLE) && (cnt_q == CntW'(FRAME_BYTES));

  always_comb begin
    q_job_o.gain_ok = (bytes_q[0] == HDR_BYTE) && (bytes_q[8] == TRL_BYTE) &&
                      (bytes_q[7] == sum_q);
    q_job_o.kp      = {bytes_q[2], bytes_q[1]};
    q_job_o.kd      = {bytes_q[4], bytes_q[3]};
    q_job_o.sp      = {bytes_q[6], bytes_q[5]};
    q_job_o.ang     = in_i.angle_tenths;
  end

  a_cnt_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(RX_WINDOW))
    else $error("burst count beyond receive window");

endmodule

[sv/gfd_fifo.sv]
// ----------------------------------------------------------------------------
// gfd_fifo
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module gfd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gfd_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output gfd_pkg::job_t job_o
);
  import gfd_pkg::*;

  job_t             mem_q [FIFO_DEPTH];
  logic [FPtrW-1:0] wr_q, rd_q;
  logic [FCntW-1:0] cnt_q;

  function automatic logic [FPtrW-1:0] wrap_inc(input logic [FPtrW-1:0] p);
    if (p == FPtrW'(FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + FPtrW'(1);
  endfunction

  assign full_o  = (cnt_q == FCntW'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wrap_inc(wr_q);
      if (pop_i)  rd_q <= wrap_inc(rd_q);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + FCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - FCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full job queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty job queue");

endmodule

[sv/gfd_back.sv]
// ----------------------------------------------------------------------------
// gfd_back
// Takes one job at a time and walks it out as an optional gain set followed
// by the five reply bytes, through a registered output stage.
// ----------------------------------------------------------------------------
module gfd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  gfd_pkg::job_t q_job_i,
  output logic          q_pop_o,
  gfd_out_if.source     out_o
);
  import gfd_pkg::*;

  typedef enum logic [2:0] {
    STEP_GAIN = 3'd0,
    STEP_HDR  = 3'd1,
    STEP_LO   = 3'd2,
    STEP_HI   = 3'd3,
    STEP_SUM  = 3'd4,
    STEP_TRL  = 3'd5
  } step_e;

  step_e              step_q, step_d;
  logic               busy_q;
  job_t               job_q;
  logic               out_valid_q;
  logic               kind_q;
  logic signed [16:0] kp_q, kd_q, sp_q;
  logic [7:0]         tx_q;
  logic               last_q;

  logic               out_free;
  logic               issue;
  logic               done;
  logic               load;
  logic [7:0]         tx_d;

  assign out_free = !out_valid_q || out_o.ready;
  assign issue    = busy_q && out_free;
  assign done     = issue && (step_q == STEP_TRL);
  assign load     = q_valid_i && (!busy_q || done);
  assign q_pop_o  = load;

  always_comb begin
    step_d = step_q;
    tx_d   = 8'h00;
    case (step_q)
      STEP_GAIN: step_d = STEP_HDR;
      STEP_HDR: begin
        step_d = STEP_LO;
        tx_d   = HDR_BYTE;
      end
      STEP_LO: begin
        step_d = STEP_HI;
        tx_d   = job_q.ang[7:0];
      end
      STEP_HI: begin
        step_d = STEP_SUM;
        tx_d   = job_q.ang[15:8];
      end
      STEP_SUM: begin
        step_d = STEP_TRL;
        tx_d   = job_q.ang[7:0] + job_q.ang[15:8];
      end
      STEP_TRL: begin
        step_d = STEP_TRL;
        tx_d   = TRL_BYTE;
      end
      default: begin
        step_d = STEP_TRL;
        tx_d   = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= STEP_HDR;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        step_q <= q_job_i.gain_ok ? STEP_GAIN : STEP_HDR;
      end else if (done) begin
        busy_q <= 1'b0;
      end else if (issue) begin
        step_q <= step_d;
      end
      if (issue) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= q_job_i;
    end
    if (issue) begin
      if (step_q == STEP_GAIN) begin
        kind_q <= KIND_GAIN;
        kp_q   <= 17'sd0 - $signed({1'b0, job_q.kp});
        kd_q   <= 17'sd0 - $signed({1'b0, job_q.kd});
        sp_q   <= 17'sd0 - $signed({1'b0, job_q.sp});
      end else begin
        kind_q <= KIND_REPLY;
        kp_q   <= '0;
        kd_q   <= '0;
        sp_q   <= '0;
      end
      tx_q   <= tx_d;
      last_q <= (step_q == STEP_TRL);
    end
  end

  assign out_o.valid               = out_valid_q;
  assign out_o.result_kind         = kind_q;
  assign out_o.angle_kp            = kp_q;
  assign out_o.angle_kd_hundredths = kd_q;
  assign out_o.speed_kp            = sp_q;
  assign out_o.tx_byte             = tx_q;
  assign out_o.last_of_run         = last_q;

  a_gain_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == KIND_GAIN) |-> (tx_q == 8'h00 && !last_q))
    else $error("gain word carries reply fields");

endmodule

[test/gfd_checker.sv]
// ----------------------------------------------------------------------------
// gfd_checker
// Watches both channels of the gain frame deframer, keeps its own model of
// the burst store, predicts gain sets and reply bytes, and compares every
// output word with the oldest prediction.
// ----------------------------------------------------------------------------
module gfd_checker (
  input  logic clk_i,
  input  logic rst_ni,
  gfd_in_if    in_w,
  gfd_out_if   out_w,
  output int   fail_count_o,
  output int   words_owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import gfd_pkg::*;

  typedef struct packed {
    logic               kind;
    logic signed [16:0] kp;
    logic signed [16:0] kd;
    logic signed [16:0] sp;
    logic [7:0]         tx;
    logic               last;
  } out_word_t;

  out_word_t   frame_out_q[$];
  int unsigned burst_len;
  logic [7:0]  burst_store [FRAME_BYTES];
  int          mismatches = 0;

  function automatic logic signed [16:0] neg_gain(logic [7:0] lo, logic [7:0] hi);
    return 17'sd0 - $signed({1'b0, hi, lo});
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic match_field(string name, logic [16:0] got, logic [16:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %05h want %05h", name, got, want));
  endtask

  // Update the burst model with one input word and queue what it causes.
  task automatic deframe_word(logic act, logic [7:0] b, logic [15:0] ang);
    logic [7:0] chk;
    logic [7:0] reply [5];
    out_word_t  w;
    if (act == ACT_BYTE) begin
      // drop bytes once the window is full
      if (burst_len < RX_WINDOW) begin
        if (burst_len < FRAME_BYTES) burst_store[burst_len] = b;
        burst_len++;
      end
    end else begin
      if (burst_len == FRAME_BYTES) begin
        chk = burst_store[1] + burst_store[2] + burst_store[3] +
              burst_store[4] + burst_store[5] + burst_store[6];
        if (burst_store[0] == HDR_BYTE && burst_store[8] == TRL_BYTE &&
            chk == burst_store[7]) begin
          w      = '0;
          w.kind = KIND_GAIN;
          w.kp   = neg_gain(burst_store[1], burst_store[2]);
          w.kd   = neg_gain(burst_store[3], burst_store[4]);
          w.sp   = neg_gain(burst_store[5], burst_store[6]);
          frame_out_q.push_back(w);
        end
        reply[0] = HDR_BYTE;
        reply[1] = ang[7:0];
        reply[2] = ang[15:8];
        reply[3] = ang[7:0] + ang[15:8];
        reply[4] = TRL_BYTE;
        for (int i = 0; i < 5; i++) begin
          w      = '0;
          w.kind = KIND_REPLY;
          w.tx   = reply[i];
          w.last = (i == 4);
          frame_out_q.push_back(w);
        end
      end
      burst_len = 0;
    end
  endtask

  task automatic check_out_word();
    out_word_t want;
    if (frame_out_q.size() == 0) begin
      report_mismatch($sformatf("unexpected word kind %0d tx %02h",
                                out_w.result_kind, out_w.tx_byte));
      return;
    end
    want = frame_out_q.pop_front();
    match_field("result_kind", 17'(out_w.result_kind), 17'(want.kind));
    match_field("angle_kp", out_w.angle_kp, want.kp);
    match_field("angle_kd_hundredths", out_w.angle_kd_hundredths, want.kd);
    match_field("speed_kp", out_w.speed_kp, want.sp);
    match_field("tx_byte", 17'(out_w.tx_byte), 17'(want.tx));
    match_field("last_of_run", 17'(out_w.last_of_run), 17'(want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_len = 0;
      frame_out_q.delete();
      words_owed_o <= 0;
      fail_count_o <= mismatches;
    end else begin
      if (out_w.valid === 1'b1 && out_w.ready === 1'b1) check_out_word();
      if (in_w.valid === 1'b1 && in_w.ready === 1'b1)
        deframe_word(in_w.action, in_w.rx_byte, in_w.angle_tenths);
      words_owed_o <= frame_out_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives bursts of serial bytes and idle events into the gain frame deframer:
// a few hand-picked frames first, then random frames, damaged frames and
// bursts of the wrong length in three phases, stalling both sides in two.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gfd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_WORDS = 100;

  logic clk_i;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   words_owed;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   words_sent = 0;
  int   cycles = 0;
  logic [7:0] frame_buf [32];

  gfd_in_if  in_ch ();
  gfd_out_if out_ch ();

  gain_frame_deframer_with_angle_reply dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  gfd_checker scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_w         (in_ch),
    .out_w        (out_ch),
    .fail_count_o (fail_count),
    .words_owed_o (words_owed)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    out_ch.ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [7:0] rand_byte();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic logic signed [15:0] rand_angle();
    int pick;
    pick = $urandom_range(19);
    if (pick < 2) return 16'sh8000;
    if (pick < 4) return 16'sh7FFF;
    if (pick == 4) return 16'sh0000;
    return 16'($urandom);
  endfunction

  task automatic send_word(logic act, logic [7:0] b, logic signed [15:0] ang);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.rx_byte      <= b;
    in_ch.angle_tenths <= ang;
    @(posedge clk_i);
    while (in_ch.ready !== 1'b1) @(posedge clk_i);
    words_sent++;
  endtask

  // Send the first len bytes of frame_buf, then close the burst with an idle.
  task automatic send_burst(int len, logic signed [15:0] ang);
    for (int i = 0; i < len; i++) send_word(ACT_BYTE, frame_buf[i], rand_angle());
    send_word(ACT_IDLE, rand_byte(), ang);
  endtask

  // Fill in header, checksum and trailer around the six gain bytes.
  task automatic seal_frame();
    logic [7:0] sum;
    sum = 8'h00;
    for (int i = 1; i <= 6; i++) sum = sum + frame_buf[i];
    frame_buf[0] = HDR_BYTE;
    frame_buf[7] = sum;
    frame_buf[8] = TRL_BYTE;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (words_owed != 0);
  endtask

  task automatic run_random(int goal);
    int pick;
    int flaw;
    int len;
    while (words_sent < goal) begin
      pick = $urandom_range(99);
      for (int i = 0; i < 32; i++) frame_buf[i] = rand_byte();
      seal_frame();
      if (pick < 60) begin
        send_burst(FRAME_BYTES, rand_angle());
      end else if (pick < 78) begin
        // damage header, trailer or checksum: reply only
        flaw = $urandom_range(2);
        len  = (flaw == 0) ? 0 : (flaw == 1) ? 8 : 7;
        frame_buf[len] = frame_buf[len] ^ 8'($urandom_range(255, 1));
        send_burst(FRAME_BYTES, rand_angle());
      end else if (pick < 92) begin
        // any length but nine, up to past the receive window
        len = $urandom_range(RX_WINDOW + 4);
        if (len >= FRAME_BYTES) len++;
        send_burst(len, rand_angle());
      end else begin
        for (int i = 0; i < FRAME_BYTES; i++) frame_buf[i] = 8'($urandom);
        send_burst(FRAME_BYTES, rand_angle());
      end
    end
  endtask

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_BYTE;
    in_ch.rx_byte      = 8'h00;
    in_ch.angle_tenths = 16'sh0000;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 28;
    recv_idle_pct = 45;

    // largest gains, most negative angle
    for (int i = 1; i <= 6; i++) frame_buf[i] = 8'hFF;
    seal_frame();
    send_burst(FRAME_BYTES, 16'sh8000);
    // zero gains, most positive angle
    for (int i = 1; i <= 6; i++) frame_buf[i] = 8'h00;
    seal_frame();
    send_burst(FRAME_BYTES, 16'sh7FFF);
    // idle on an empty burst, then a short burst: no output
    send_burst(0, rand_angle());
    send_burst(2, rand_angle());

    // hold off until the block has drained
    in_ch.valid <= 1'b0;
    wait_drained();

    run_random(words_sent + PHASE_WORDS);
    send_idle_pct = 45;
    recv_idle_pct = 28;
    run_random(words_sent + PHASE_WORDS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(words_sent + PHASE_WORDS);

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (30) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
